>>> src/fua_pkg.sv
// Package for the H.264 RTP FU-A packetizer: parse phases, emit descriptor,
// beat positions and fixed protocol constants. No dependencies.
package fua_pkg;

    // Parse phase of the current NAL buffer
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_CODE     = 5'b00010,
        PH_SINGLE   = 5'b00100,
        PH_FU_FIRST = 5'b01000,
        PH_FU_REST  = 5'b10000
    } phase_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAYLOAD_TYPE = 2'd0;
    localparam logic [1:0] CFG_SOURCE_ID    = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd2;

    // Reset values of registers and state
    localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
    localparam logic [31:0] SOURCE_ID_RST    = 32'd1231;
    localparam logic [10:0] MAX_PAYLOAD_RST  = 11'd1400;
    localparam logic [15:0] SEQUENCE_RST     = 16'd1224;

    // Largest accepted buffer, in bytes
    localparam logic [23:0] MAX_BUFFER_BYTES = 24'd65535;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [4:0] FU_A_TYPE        = 5'd28;

    // Beat positions within one emitted burst
    localparam logic [3:0] POS_HDR_FIRST = 4'd0;
    localparam logic [3:0] POS_HDR_LAST  = 4'd11;
    localparam logic [3:0] POS_FU_IND    = 4'd12;
    localparam logic [3:0] POS_FU_HDR    = 4'd13;
    localparam logic [3:0] POS_DATA      = 4'd14;

    // m_tuser bit positions
    localparam int USER_START = 0;
    localparam int USER_END   = 1;
    localparam int USER_ERR   = 2;

    // Everything one input byte causes on the output side
    typedef struct packed {
        logic        has_hdr;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic        has_fu;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        data_end;
        logic        err;
    } desc_t;

endpackage

>>> src/h264_rtp_fu_a_packetizer.sv
// Top level of the H.264 RTP packetizer (single NAL unit or FU-A fragments).
// Instantiates fua_parser and fua_emitter; depends on fua_pkg.
//
// Usage:
//   s_ channel: one beat per byte of a NAL buffer, start code included.
//     s_tuser marks the first byte of a buffer; buffer size and timestamp
//     increment ride in s_tdata and are read only on that first byte.
//   m_ channel: RTP packet bytes, one per beat. m_tuser flags packet start,
//     packet end and a dropped buffer (error beat, data zero). m_tlast closes
//     the run of beats caused by one input byte.
//   cfg port: write-only registers (payload type, SSRC, max payload), written
//     on any edge with cfg_wr_en high; change them only while idle.
// Output: a byte's first beat is registered and appears in the cycle after it is taken.
// Throughput: a payload byte in the middle of a packet is a single beat, so the
//   stream runs at one byte per cycle while m_tready stays high. A byte that opens
//   a packet costs 13 beats (single NAL) or 15 beats (FU-A fragment), set by the
//   single burst register that walks the header; s_tready stays low until its last beat.
// Receiver stall: the burst register holds its beat; s_tready drops unless the
//   held beat is the last of its run and is taken in that cycle.
// Reset: synchronous, active low; registers return to their defaults,
//   sequence number to 1224, timestamp to zero, parser to idle.
module h264_rtp_fu_a_packetizer import fua_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // data_byte[7:0], buffer_size[23:8], time_increase[55:24]
    input  logic        s_tuser,   // first_byte
    // RTP byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic [2:0]  m_tuser,   // packet_start[0], packet_end[1], error[2]
    output logic        m_tlast    // run_last
);

    logic [6:0]  payload_type_reg;
    logic [31:0] source_id_reg;
    logic [10:0] max_payload_reg;

    logic        accept;
    logic        can_load;
    logic        desc_valid;
    desc_t       desc;

    // Configuration registers; out-of-list indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_type_reg <= PAYLOAD_TYPE_RST;
            source_id_reg    <= SOURCE_ID_RST;
            max_payload_reg  <= MAX_PAYLOAD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PAYLOAD_TYPE: payload_type_reg <= cfg_wdata[6:0];
                CFG_SOURCE_ID:    source_id_reg    <= cfg_wdata;
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // Take a byte whenever the burst register is free or frees this cycle
    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    fua_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_tdata[7:0]),
        .first_byte    (s_tuser),
        .buffer_size   (s_tdata[23:8]),
        .time_increase (s_tdata[55:24]),
        .max_payload   (max_payload_reg),
        .desc_valid    (desc_valid),
        .desc          (desc)
    );

    // Load only bytes that cause output; silent bytes just advance the parser
    fua_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept && desc_valid),
        .load_desc    (desc),
        .payload_type (payload_type_reg),
        .source_id    (source_id_reg),
        .can_load     (can_load),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    a_no_take_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !(m_tready && m_tlast)) |-> !s_tready)
        else $error("input taken while a run is still pending");

endmodule

>>> src/fua_parser.sv
// Start-code parser and packet state for the FU-A packetizer: turns each
// accepted byte into a burst descriptor. Depends on fua_pkg.
module fua_parser import fua_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic [15:0] buffer_size,
    input  logic [31:0] time_increase,
    input  logic [10:0] max_payload,
    output logic        desc_valid,
    output desc_t       desc
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  bp_reg, bp_next;
    logic [15:0] pl_reg, pl_next;
    logic [10:0] fc_reg, fc_next;
    logic [7:0]  nh_reg, nh_next;
    logic [31:0] pend_reg, pend_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;

    logic [10:0] frag;
    logic [15:0] pos1;
    logic [15:0] len;
    logic        skip, bad, hdr, last_frag, s_bit, end_beat;

    assign frag = (max_payload == 11'd0) ? 11'd1 : max_payload;

    always_comb begin
        phase_next = phase_reg;
        bp_next    = bp_reg;
        pl_next    = pl_reg;
        fc_next    = fc_reg;
        nh_next    = nh_reg;
        pend_next  = pend_reg;
        seq_next   = seq_reg;
        ts_next    = ts_reg;
        desc       = '0;
        desc_valid = 1'b0;
        skip       = 1'b0;
        bad        = 1'b0;
        hdr        = 1'b0;
        len        = '0;
        last_frag  = 1'b0;
        s_bit      = 1'b0;
        end_beat   = 1'b0;

        if (first_byte) begin
            bp_next    = '0;
            pl_next    = buffer_size;
            pend_next  = time_increase;
            fc_next    = '0;
            nh_next    = '0;
            phase_next = PH_CODE;
            if (({8'd0, buffer_size} > MAX_BUFFER_BYTES) || (buffer_size == 16'd0)) begin
                // drop oversize or empty buffer with one error beat
                desc.err   = 1'b1;
                desc_valid = 1'b1;
                phase_next = PH_IDLE;
                pl_next    = '0;
                skip       = 1'b1;
            end
        end

        // offset of the byte after this one within the start code
        pos1 = {13'd0, bp_next} + 16'd1;

        if (!skip) begin
            case (phase_next)
                PH_CODE: begin
                    if (bp_next < 3'd2) begin
                        bad = (data_byte != 8'd0);
                    end else if (bp_next == 3'd2) begin
                        bad     = (data_byte != 8'd0) && (data_byte != 8'd1);
                        nh_next = data_byte;
                    end else if (bp_next == 3'd3) begin
                        if (nh_next == 8'd1) hdr = 1'b1;
                        else bad = (data_byte != 8'd1);
                    end else begin
                        hdr = 1'b1;
                    end

                    if (bad) begin
                        desc.err   = 1'b1;
                        desc_valid = 1'b1;
                        phase_next = PH_IDLE;
                    end else if (hdr) begin
                        len       = pl_next - pos1;
                        nh_next   = data_byte;
                        ts_next   = ts_next + pend_next;
                        pl_next   = len;
                        if (len <= {5'd0, frag}) begin
                            // whole NAL fits: one packet, header byte goes out now
                            seq_next      = seq_next + 16'd1;
                            desc.has_hdr  = 1'b1;
                            desc.marker   = 1'b1;
                            desc.seq      = seq_next;
                            desc.ts       = ts_next;
                            desc.data     = data_byte;
                            desc.data_end = (len == 16'd0);
                            desc_valid    = 1'b1;
                            phase_next    = (len == 16'd0) ? PH_IDLE : PH_SINGLE;
                        end else begin
                            fc_next    = '0;
                            phase_next = PH_FU_FIRST;
                        end
                    end else if (pos1 >= pl_next) begin
                        desc.err   = 1'b1;
                        desc_valid = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        bp_next = pos1[2:0];
                    end
                end
                PH_SINGLE: begin
                    pl_next       = pl_next - 16'd1;
                    desc.data     = data_byte;
                    desc.data_end = (pl_next == 16'd0);
                    desc_valid    = 1'b1;
                    if (pl_next == 16'd0) phase_next = PH_IDLE;
                end
                PH_FU_FIRST, PH_FU_REST: begin
                    if (fc_next == 11'd0) begin
                        // open a fragment: RTP header plus FU indicator and FU header
                        last_frag    = (pl_next <= {5'd0, frag});
                        s_bit        = (phase_next == PH_FU_FIRST);
                        seq_next     = seq_next + 16'd1;
                        desc.has_hdr = 1'b1;
                        desc.has_fu  = 1'b1;
                        desc.marker  = last_frag;
                        desc.seq     = seq_next;
                        desc.ts      = ts_next;
                        desc.fu_ind  = {nh_next[7:5], FU_A_TYPE};
                        desc.fu_hdr  = {s_bit, last_frag, 1'b0, nh_next[4:0]};
                        phase_next   = PH_FU_REST;
                    end
                    fc_next       = fc_next + 11'd1;
                    pl_next       = pl_next - 16'd1;
                    end_beat      = (pl_next == 16'd0) || (fc_next >= frag);
                    desc.data     = data_byte;
                    desc.data_end = end_beat;
                    desc_valid    = 1'b1;
                    if (end_beat) fc_next = '0;
                    if (pl_next == 16'd0) phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bp_reg    <= '0;
            pl_reg    <= '0;
            fc_reg    <= '0;
            nh_reg    <= '0;
            pend_reg  <= '0;
            seq_reg   <= SEQUENCE_RST;
            ts_reg    <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            bp_reg    <= bp_next;
            pl_reg    <= pl_next;
            fc_reg    <= fc_next;
            nh_reg    <= nh_next;
            pend_reg  <= pend_next;
            seq_reg   <= seq_next;
            ts_reg    <= ts_next;
        end
    end

    // start code is at most four bytes, header byte comes by offset four
    a_code_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CODE) |-> (bp_reg <= 3'd4))
        else $error("start code position ran past header byte");

endmodule

>>> src/fua_emitter.sv
// Burst register and byte sequencer for the FU-A packetizer: holds one
// descriptor and walks its header, FU and data beats. Depends on fua_pkg.
module fua_emitter import fua_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  desc_t       load_desc,
    input  logic [6:0]  payload_type,
    input  logic [31:0] source_id,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    logic [3:0]  pos_reg, pos_next;
    desc_t       desc_reg, desc_next;
    logic        at_last;

    assign at_last  = (pos_reg == POS_DATA);
    assign can_load = !valid_reg || (m_tready && at_last);

    always_comb begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        desc_next  = desc_reg;
        if (load) begin
            valid_next = 1'b1;
            desc_next  = load_desc;
            pos_next   = load_desc.has_hdr ? POS_HDR_FIRST : POS_DATA;
        end else if (valid_reg && m_tready) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else if (pos_reg == POS_HDR_LAST) begin
                pos_next = desc_reg.has_fu ? POS_FU_IND : POS_DATA;
            end else begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= POS_DATA;
        end else begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
        desc_reg <= desc_next;
    end

    always_comb begin
        case (pos_reg)
            4'd0:    m_tdata = RTP_VERSION_BYTE;
            4'd1:    m_tdata = {desc_reg.marker, payload_type};
            4'd2:    m_tdata = desc_reg.seq[15:8];
            4'd3:    m_tdata = desc_reg.seq[7:0];
            4'd4:    m_tdata = desc_reg.ts[31:24];
            4'd5:    m_tdata = desc_reg.ts[23:16];
            4'd6:    m_tdata = desc_reg.ts[15:8];
            4'd7:    m_tdata = desc_reg.ts[7:0];
            4'd8:    m_tdata = source_id[31:24];
            4'd9:    m_tdata = source_id[23:16];
            4'd10:   m_tdata = source_id[15:8];
            4'd11:   m_tdata = source_id[7:0];
            4'd12:   m_tdata = desc_reg.fu_ind;
            4'd13:   m_tdata = desc_reg.fu_hdr;
            4'd14:   m_tdata = desc_reg.data;
            default: m_tdata = 8'd0;
        endcase
    end

    assign m_tvalid             = valid_reg;
    assign m_tlast              = at_last;
    assign m_tuser[USER_START]  = (pos_reg == POS_HDR_FIRST);
    assign m_tuser[USER_END]    = at_last && desc_reg.data_end;
    assign m_tuser[USER_ERR]    = at_last && desc_reg.err;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (pos_reg <= POS_DATA))
        else $error("beat position out of range");

    a_err_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && desc_reg.err) |-> (at_last && !desc_reg.has_hdr))
        else $error("error beat mixed with packet beats");

    a_fu_has_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (pos_reg == POS_FU_IND)) |-> desc_reg.has_fu)
        else $error("FU indicator beat without FU burst");

    a_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_tready && !at_last && !load) |=> valid_reg)
        else $error("burst dropped before its last beat");

endmodule

>>> test/tb.sv
// Self-checking testbench for h264_rtp_fu_a_packetizer: streams NAL buffers into
// the block and checks every RTP beat against a scoreboard with its own packetizer.
// Depends on fua_pkg and the h264_rtp_fu_a_packetizer RTL only.
module tb;
    import fua_pkg::*;

    // Bound on consecutive cycles with no beat on either side; the longest
    // legal quiet stretch is the forced receiver hold plus a settle wait.
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 30;

    // Scoreboard: tracks registers and packetizer state, turns every accepted
    // input byte into the RTP beats it must produce, and matches beats in order.
    class rtp_scoreboard;
        typedef struct {
            bit [7:0] octet;
            bit       pkt_start;
            bit       pkt_end;
            bit       err;
            bit       run_last;
        } beat_t;

        bit [6:0]    payload_type;
        bit [31:0]   ssrc;
        bit [10:0]   max_payload;
        bit [15:0]   seq_num;
        bit [31:0]   timestamp;
        bit [31:0]   ts_step;
        bit [7:0]    nal_header;
        int unsigned code_pos;
        int unsigned bytes_left;
        int unsigned frag_fill;
        phase_t      phase;

        beat_t beats_due[$];
        beat_t run[$];

        int mismatches;
        int n_inputs;
        int n_beats;
        int n_packets;
        int n_drops;

        function new();
            payload_type = PAYLOAD_TYPE_RST;
            ssrc         = SOURCE_ID_RST;
            max_payload  = MAX_PAYLOAD_RST;
            seq_num      = SEQUENCE_RST;
            timestamp    = '0;
            ts_step      = '0;
            nal_header   = '0;
            code_pos     = 0;
            bytes_left   = 0;
            frag_fill    = 0;
            phase        = PH_IDLE;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] value);
            case (idx)
                CFG_PAYLOAD_TYPE: payload_type = value[6:0];
                CFG_SOURCE_ID:    ssrc         = value;
                CFG_MAX_PAYLOAD:  max_payload  = value[10:0];
                default: ;
            endcase
        endfunction

        function void emit(bit [7:0] o, bit s, bit e, bit err);
            beat_t b;
            b.octet     = o;
            b.pkt_start = s;
            b.pkt_end   = e;
            b.err       = err;
            b.run_last  = 1'b0;
            run.push_back(b);
        endfunction

        function void emit_rtp_header(bit marker);
            emit(RTP_VERSION_BYTE, 1'b1, 1'b0, 1'b0);
            emit({marker, payload_type}, 1'b0, 1'b0, 1'b0);
            emit(seq_num[15:8], 1'b0, 1'b0, 1'b0);
            emit(seq_num[7:0], 1'b0, 1'b0, 1'b0);
            emit(timestamp[31:24], 1'b0, 1'b0, 1'b0);
            emit(timestamp[23:16], 1'b0, 1'b0, 1'b0);
            emit(timestamp[15:8], 1'b0, 1'b0, 1'b0);
            emit(timestamp[7:0], 1'b0, 1'b0, 1'b0);
            emit(ssrc[31:24], 1'b0, 1'b0, 1'b0);
            emit(ssrc[23:16], 1'b0, 1'b0, 1'b0);
            emit(ssrc[15:8], 1'b0, 1'b0, 1'b0);
            emit(ssrc[7:0], 1'b0, 1'b0, 1'b0);
        endfunction

        // Packetize one accepted input byte and queue the beats it causes.
        function void take_byte(bit [7:0] d, bit first, bit [15:0] size, bit [31:0] inc);
            int unsigned frag;
            int unsigned len;
            bit          bad;
            bit          hdr;
            bit          last_frag;
            bit          stop;
            beat_t       tail;
            frag = (max_payload == 0) ? 1 : max_payload;
            n_inputs++;
            run.delete();
            if (first) begin
                code_pos   = 0;
                bytes_left = size;
                ts_step    = inc;
                frag_fill  = 0;
                nal_header = '0;
                phase      = PH_CODE;
                if (size == 0) begin
                    emit(8'h00, 1'b0, 1'b0, 1'b1);
                    phase = PH_IDLE;
                end
            end
            case (phase)
                PH_CODE: begin
                    bad = 1'b0;
                    hdr = 1'b0;
                    if (code_pos < 2) begin
                        bad = (d != 0);
                    end else if (code_pos == 2) begin
                        bad = (d != 0 && d != 1);
                        nal_header = d;
                    end else if (code_pos == 3) begin
                        if (nal_header == 1) hdr = 1'b1;
                        else bad = (d != 1);
                    end else begin
                        hdr = 1'b1;
                    end
                    if (bad) begin
                        emit(8'h00, 1'b0, 1'b0, 1'b1);
                        phase = PH_IDLE;
                    end else if (hdr) begin
                        len        = bytes_left - (code_pos + 1);
                        nal_header = d;
                        timestamp  = timestamp + ts_step;
                        bytes_left = len;
                        if (len <= frag) begin
                            seq_num = seq_num + 16'd1;
                            emit_rtp_header(1'b1);
                            emit(d, 1'b0, len == 0, 1'b0);
                            phase = (len == 0) ? PH_IDLE : PH_SINGLE;
                        end else begin
                            frag_fill = 0;
                            phase     = PH_FU_FIRST;
                        end
                    end else if (code_pos + 1 >= bytes_left) begin
                        emit(8'h00, 1'b0, 1'b0, 1'b1);
                        phase = PH_IDLE;
                    end else begin
                        code_pos = code_pos + 1;
                    end
                end
                PH_SINGLE: begin
                    bytes_left = bytes_left - 1;
                    emit(d, 1'b0, bytes_left == 0, 1'b0);
                    if (bytes_left == 0) phase = PH_IDLE;
                end
                PH_FU_FIRST, PH_FU_REST: begin
                    if (frag_fill == 0) begin
                        last_frag = (bytes_left <= frag);
                        seq_num   = seq_num + 16'd1;
                        emit_rtp_header(last_frag);
                        emit({nal_header[7:5], FU_A_TYPE}, 1'b0, 1'b0, 1'b0);
                        emit({phase == PH_FU_FIRST, last_frag, 1'b0, nal_header[4:0]},
                             1'b0, 1'b0, 1'b0);
                        phase = PH_FU_REST;
                    end
                    frag_fill  = frag_fill + 1;
                    bytes_left = bytes_left - 1;
                    stop = (bytes_left == 0) || (frag_fill >= frag);
                    emit(d, 1'b0, stop, 1'b0);
                    if (stop) frag_fill = 0;
                    if (bytes_left == 0) phase = PH_IDLE;
                end
                default: ;
            endcase
            if (run.size() > 0) begin
                tail = run.pop_back();
                tail.run_last = 1'b1;
                run.push_back(tail);
            end
            foreach (run[i]) beats_due.push_back(run[i]);
        endfunction

        // Match one accepted output beat against the oldest expected beat.
        function void check_beat(logic [7:0] o, logic [2:0] user, logic last);
            beat_t want;
            n_beats++;
            if (user[USER_START] === 1'b1) n_packets++;
            if (user[USER_ERR] === 1'b1) n_drops++;
            if (beats_due.size() == 0) begin
                report($sformatf("unexpected beat data=%02h user=%03b last=%b", o, user, last));
                return;
            end
            want = beats_due.pop_front();
            if (o !== want.octet || user[USER_START] !== want.pkt_start ||
                user[USER_END] !== want.pkt_end || user[USER_ERR] !== want.err ||
                last !== want.run_last)
                report($sformatf({"beat %0d: got data=%02h start=%b end=%b err=%b last=%b,",
                                  " want %02h %b %b %b %b"},
                                 n_beats, o, user[USER_START], user[USER_END],
                                 user[USER_ERR], last, want.octet, want.pkt_start,
                                 want.pkt_end, want.err, want.run_last));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // data_byte[7:0], buffer_size[23:8], time_increase[55:24]
    logic        s_tuser;   // first_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic [2:0]  m_tuser;   // packet_start[0], packet_end[1], error[2]
    logic        m_tlast;   // run_last

    rtp_scoreboard sb = new();

    // Quiet turns off random idling on both sides; hold_asked bumps request
    // a long receiver hold. Both are written with NBAs so the reader never races.
    bit quiet;
    int hold_asked;
    int items_sent;

    h264_rtp_fu_a_packetizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Monitor: sample both channels with pre-edge values. An input beat taken
    // at this edge cannot cause an output beat at the same edge, so order is free.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                sb.take_byte(s_tdata[7:0], s_tuser, s_tdata[23:8], s_tdata[55:24]);
        end
    end

    // Receiver: take beats at random, drop ready with a chance of about 9 in 100,
    // stay ready while quiet, and hold off for HOLD_CYCLES when asked.
    initial begin : receiver
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_done) begin
                hold_done = hold_done + 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 9);
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel; bail out at the limit.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d beats still due",
                         STALL_LIMIT, sb.beats_due.size());
                $display("** h264_rtp_fu_a_packetizer: FAILED **");
                $finish;
            end
        end
    end

    // Offer one input beat and hold it until the block takes it. Size and
    // increment only matter on a first byte; elsewhere drive noise there.
    // Ignored bytes (strays) do not count toward the item budget.
    task automatic send_byte(input bit [7:0] d, input bit first, input bit [15:0] size,
                             input bit [31:0] inc, input bit counted);
        if (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        if (first) s_tdata <= {inc, size, d};
        else       s_tdata <= {32'($urandom), 16'($urandom), d};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counted) items_sent++;
    endtask

    // Send the first n_send bytes of a buffer: start code of code_len bytes,
    // random NAL header, random payload. bad_at >= 0 corrupts that code byte.
    task automatic send_buffer(input int code_len, input bit [15:0] size, input int n_send,
                               input int bad_at, input bit [31:0] inc);
        bit [7:0] d;
        for (int i = 0; i < n_send; i++) begin
            if (i == bad_at)             d = 8'($urandom_range(2, 255));
            else if (i < code_len - 1)   d = 8'h00;
            else if (i == code_len - 1)  d = 8'h01;
            else                         d = 8'($urandom);
            send_byte(d, i == 0, size, inc, 1'b1);
        end
    endtask

    // One random buffer: mostly well-formed NALs sized around the fragment
    // size (fits, exact multiple, one over), the rest broken or abandoned.
    task automatic random_buffer(input int frag);
        int        code_len;
        int        n;
        int        r;
        int        cap;
        int        bad_at;
        bit [15:0] size;
        bit [31:0] inc;
        code_len = $urandom_range(3, 4);
        r        = $urandom_range(99);
        cap      = (frag > 40) ? 40 : 3 * frag;
        case ($urandom_range(9))
            0:       inc = 32'h0000_0000;
            1:       inc = 32'hFFFF_FFFF;
            default: inc = $urandom;
        endcase
        if (r < 80) begin
            case ($urandom_range(7))
                0:       n = 0;
                1:       n = (frag <= cap) ? frag : $urandom_range(1, cap);
                2:       n = (2 * frag <= cap) ? 2 * frag : $urandom_range(1, cap);
                3:       n = (frag + 1 <= cap) ? frag + 1 : $urandom_range(1, cap);
                default: n = $urandom_range(1, cap);
            endcase
            size = 16'(code_len + 1 + n);
            send_buffer(code_len, size, size, -1, inc);
            if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'b0, 16'd0, 32'd0, 1'b0);
        end else if (r < 85) begin
            // broken start code, then a stray byte that must be ignored
            bad_at = $urandom_range(0, code_len - 1);
            size   = 16'($urandom_range(code_len + 1, 200));
            send_buffer(code_len, size, bad_at + 1, bad_at, inc);
            send_byte(8'($urandom), 1'b0, 16'd0, 32'd0, 1'b0);
        end else if (r < 90) begin
            // buffer ends before its NAL header byte
            size = 16'($urandom_range(1, code_len));
            send_buffer(code_len, size, size, -1, inc);
        end else if (r < 94) begin
            send_byte(8'($urandom), 1'b1, 16'd0, inc, 1'b1);
        end else begin
            // huge buffer cut short by the next first byte
            size = 16'($urandom_range(16'h0400, 16'hFFFF));
            send_buffer(code_len, size, code_len + 1 + $urandom_range(1, cap), -1, inc);
        end
    endtask

    // Random traffic up to the item budget, closed by a complete buffer so
    // the parser is idle before the next register change.
    task automatic run_phase(input int budget, input int frag);
        int stop_at;
        int code_len;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) random_buffer(frag);
        code_len = $urandom_range(3, 4);
        send_buffer(code_len, 16'(code_len + 2), code_len + 2, -1, $urandom);
    endtask

    // Drop valid and wait until every expected beat is out, then let the
    // block settle before anything touches the registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.beats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges; upper data bits carry
    // noise that the narrow registers must drop.
    task automatic program_regs(input bit [6:0] pt, input bit [31:0] ssrc,
                                input bit [10:0] max_pl);
        bit [1:0]  idx [3];
        bit [31:0] val [3];
        idx[0] = CFG_PAYLOAD_TYPE;
        idx[1] = CFG_SOURCE_ID;
        idx[2] = CFG_MAX_PAYLOAD;
        val[0] = {25'($urandom), pt};
        val[1] = ssrc;
        val[2] = {21'($urandom), max_pl};
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int frag3;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_PAYLOAD_TYPE;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        quiet      = 1'b0;
        hold_asked = 0;
        items_sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed corner cases at reset register values.
        send_byte(8'hFF, 1'b0, 16'd0, 32'd0, 1'b0);            // stray before any buffer
        send_byte(8'hFF, 1'b1, 16'd0, 32'hFFFF_FFFF, 1'b1);    // size zero
        send_byte(8'h80, 1'b1, 16'hFFFF, $urandom, 1'b1);      // bad code on first byte
        send_byte(8'h00, 1'b0, 16'd0, 32'd0, 1'b0);            // ignored tail
        send_buffer(3, 16'd3, 3, -1, $urandom);                // too short for header
        send_buffer(3, 16'd4, 4, -1, 32'hFFFF_FFFF);           // empty payload, 3-byte code
        send_buffer(4, 16'd5, 5, -1, 32'd1);                   // empty payload, timestamp wraps
        send_buffer(4, 16'h8000, 7, -1, $urandom);             // abandoned mid-packet
        send_buffer(4, 16'd10, 4, 3, $urandom);                // 4-byte code broken at its 01
        drain();

        // Smallest fragment size, extreme header fields; stall the receiver
        // long enough that the block backs up into the input.
        program_regs(7'h7F, 32'hFFFF_FFFF, 11'd16);
        hold_asked <= hold_asked + 1;
        run_phase(30, 16);
        drain();

        // Largest fragment size, zero header fields, no idling at all.
        program_regs(7'h00, 32'h0000_0000, 11'd1500);
        quiet <= 1'b1;
        run_phase(25, 1500);
        drain();
        quiet <= 1'b0;

        // Random settings with small fragments.
        frag3 = $urandom_range(16, 24);
        program_regs(7'($urandom), $urandom, 11'(frag3));
        run_phase(35, frag3);
        drain();

        while (sb.beats_due.size() != 0) begin
            sb.report("expected beat never arrived");
            void'(sb.beats_due.pop_front());
        end
        $display("tb: %0d input beats, %0d output beats, %0d RTP packets, %0d dropped buffers",
                 sb.n_inputs, sb.n_beats, sb.n_packets, sb.n_drops);
        $display("tb: four register settings, bad/short/abandoned buffers, long receiver stall");
        if (sb.mismatches == 0) begin
            $display("** h264_rtp_fu_a_packetizer: PASSED **");
        end else begin
            $display("** h264_rtp_fu_a_packetizer: FAILED **");
        end
        $finish;
    end

endmodule
